FILE: rtl/clsr_pkg.sv
// ----------------------------------------------------------------------------
// clsr_pkg: shared types and constants of the combined lcg shuffle generator
// Field widths, register map and reset values used by the interfaces and
// the top level.
// ----------------------------------------------------------------------------
package clsr_pkg;

	localparam int VAL_W          = 31;
	localparam int SEED_W         = 32;
	localparam int MULT_W         = 16;
	localparam int APB_ADDR_W     = 5;
	localparam int APB_DATA_W     = 32;
	localparam int DEF_TABLE_SIZE = 32;

	typedef logic [VAL_W-1:0]  val_t;
	typedef logic [MULT_W-1:0] mult_t;

	// operation codes of a command word
	typedef enum logic {
		OP_DRAW   = 1'b0,
		OP_RESEED = 1'b1
	} op_t;

	// register indexes of the configuration port
	typedef enum logic [2:0] {
		REG_FIRST_MULT  = 3'd0,
		REG_FIRST_MOD   = 3'd1,
		REG_FIRST_QUOT  = 3'd2,
		REG_FIRST_REM   = 3'd3,
		REG_SECOND_MULT = 3'd4,
		REG_SECOND_MOD  = 3'd5,
		REG_SECOND_QUOT = 3'd6,
		REG_SECOND_REM  = 3'd7
	} reg_idx_t;

	localparam mult_t RST_FIRST_MULT  = 16'd40014;
	localparam val_t  RST_FIRST_MOD   = 31'd2147483563;
	localparam val_t  RST_FIRST_QUOT  = 31'd53668;
	localparam mult_t RST_FIRST_REM   = 16'd12211;
	localparam mult_t RST_SECOND_MULT = 16'd40692;
	localparam val_t  RST_SECOND_MOD  = 31'd2147483399;
	localparam val_t  RST_SECOND_QUOT = 31'd52774;
	localparam mult_t RST_SECOND_REM  = 16'd3791;

endpackage

FILE: rtl/clsr_cmd_if.sv
// ----------------------------------------------------------------------------
// clsr_cmd_if: command channel of the generator
// Carries a draw or reseed word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface clsr_cmd_if;
	import clsr_pkg::*;

	logic              valid;
	logic              ready;
	logic              op;
	logic [SEED_W-1:0] seed_value;

	modport source (output valid, output op, output seed_value, input ready);
	modport sink   (input valid, input op, input seed_value, output ready);
endinterface

FILE: rtl/clsr_res_if.sv
// ----------------------------------------------------------------------------
// clsr_res_if: result channel of the generator
// Carries one random value per draw with valid/ready handshake.
// ----------------------------------------------------------------------------
interface clsr_res_if;
	import clsr_pkg::*;

	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] random_value;

	modport source (output valid, output random_value, input ready);
	modport sink   (input valid, input random_value, output ready);
endinterface

FILE: rtl/combined_lcg_shuffle_rng.sv
// A draw runs four 31-step bit-serial divisions, two multiply and two finish
// steps, then table read, update and output steps, the output step waiting on
// a stalled receiver; a reseed fills the table. One command is
// worked on at a time and the next is taken the cycle after the previous ends.
// Reset: asynchronous, active low; registers return to defaults, generator
// state and the shuffle table read as zero.
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng: combined lcg generator with shuffle table
// Two Schrage-stepped congruential generators mixed through a shuffle table,
// using one bit-serial divider shared by all divisions.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng #(
	parameter int TABLE_SIZE = clsr_pkg::DEF_TABLE_SIZE
) (
	input  logic                            clk,
	input  logic                            arst_n,
	clsr_cmd_if.sink                        cmd,
	clsr_res_if.source                      res,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [clsr_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [clsr_pkg::APB_DATA_W-1:0] pwdata,
	output logic [clsr_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);
	import clsr_pkg::*;

	localparam int IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int JW = $clog2(TABLE_SIZE + 8);
	localparam int PW = VAL_W + MULT_W;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DIV, ST_MUL, ST_FIN, ST_READ, ST_CALC, ST_PUSH
	} state_t;

	typedef enum logic [2:0] {
		PH_S1, PH_S2, PH_RESEED, PH_TOP, PH_SLOT
	} phase_t;

	state_t state_q;
	phase_t phase_q;

	// configuration registers
	mult_t a1_q, r1_q, a2_q, r2_q;
	val_t  m1_q, q1_q, m2_q, q2_q;

	// generator state
	val_t  s1_q, s2_q, shuf_q;
	logic [JW-1:0] j_q;
	logic [IW-1:0] slot_q;

	// divider
	val_t       dq_q, dsr_q, rem_q;
	logic [4:0] cnt_q;

	logic [PW-1:0] p1_q, p2_q;
	val_t          out_q;
	logic          out_v_q;

	// shuffle table
	val_t            mem [TABLE_SIZE];
	logic [TABLE_SIZE-1:0] vld_q;
	val_t            rd_q;
	logic            rd_vld_q;
	logic            mem_we;
	logic [IW-1:0]   mem_wa;
	val_t            mem_wd;

	// apb write decode
	logic     cfg_we;
	reg_idx_t cfg_idx;
	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);

	always_comb begin
		unique case (cfg_idx)
			REG_FIRST_MULT:  prdata = {16'd0, a1_q};
			REG_FIRST_MOD:   prdata = {1'b0, m1_q};
			REG_FIRST_QUOT:  prdata = {1'b0, q1_q};
			REG_FIRST_REM:   prdata = {16'd0, r1_q};
			REG_SECOND_MULT: prdata = {16'd0, a2_q};
			REG_SECOND_MOD:  prdata = {1'b0, m2_q};
			REG_SECOND_QUOT: prdata = {1'b0, q2_q};
			REG_SECOND_REM:  prdata = {16'd0, r2_q};
			default:         prdata = '0;
		endcase
	end

	// quotients of zero taken as one, top of the first modulus
	val_t qq1, qq2, top;
	assign qq1 = (q1_q == '0) ? val_t'(1) : q1_q;
	assign qq2 = (q2_q == '0) ? val_t'(1) : q2_q;
	assign top = (m1_q == '0) ? '0 : m1_q - val_t'(1);

	// seed magnitude, saturated, zero taken as one
	logic [SEED_W-1:0] seed_neg;
	val_t              seed_mag;
	always_comb begin
		seed_neg = -cmd.seed_value;
		if (cmd.seed_value[SEED_W-1]) begin
			seed_mag = seed_neg[SEED_W-1] ? '1 : seed_neg[VAL_W-1:0];
		end else begin
			seed_mag = cmd.seed_value[VAL_W-1:0];
		end
		if (seed_mag == '0) begin
			seed_mag = val_t'(1);
		end
	end

	// one restoring divider step
	logic [VAL_W:0] trial;
	logic           fits;
	assign trial = {rem_q, dq_q[VAL_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	// schrage finish: a*rem - r*k, modulus added when negative
	logic          use2;
	logic [PW:0]   ydiff;
	val_t          ysch;
	assign use2  = (phase_q == PH_S2);
	always_comb begin
		ydiff = {1'b0, p1_q} - {1'b0, p2_q};
		if (ydiff[PW]) begin
			ydiff = ydiff + {{(PW+1-VAL_W){1'b0}}, (use2 ? m2_q : m1_q)};
		end
		ysch = ydiff[VAL_W-1:0];
	end

	// shuffle output: table entry minus second state, wrapped below one
	val_t           tab_val;
	logic [VAL_W+1:0] ydraw;
	val_t           ynew;
	assign tab_val = rd_vld_q ? rd_q : '0;
	always_comb begin
		ydraw = {2'b00, tab_val} - {2'b00, s2_q};
		if (ydraw[VAL_W+1] || (ydraw == '0)) begin
			ydraw = ydraw + {2'b00, top};
		end
		ynew = ydraw[VAL_W-1:0];
	end

	// slot index with saturation
	logic [IW-1:0] slot_sat;
	assign slot_sat = (dq_q >= val_t'(TABLE_SIZE)) ? IW'(TABLE_SIZE - 1) : dq_q[IW-1:0];

	// table write port
	always_comb begin
		mem_we = 1'b0;
		mem_wa = slot_q;
		mem_wd = s1_q;
		if (state_q == ST_FIN && phase_q == PH_RESEED && j_q < JW'(TABLE_SIZE)) begin
			mem_we = 1'b1;
			mem_wa = j_q[IW-1:0];
			mem_wd = ysch;
		end else if (state_q == ST_CALC) begin
			mem_we = 1'b1;
		end
	end

	// table memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[slot_q];
	end

	assign cmd.ready        = (state_q == ST_IDLE);
	assign res.valid        = out_v_q;
	assign res.random_value = out_q;

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			phase_q  <= PH_S1;
			a1_q     <= RST_FIRST_MULT;
			m1_q     <= RST_FIRST_MOD;
			q1_q     <= RST_FIRST_QUOT;
			r1_q     <= RST_FIRST_REM;
			a2_q     <= RST_SECOND_MULT;
			m2_q     <= RST_SECOND_MOD;
			q2_q     <= RST_SECOND_QUOT;
			r2_q     <= RST_SECOND_REM;
			s1_q     <= '0;
			s2_q     <= '0;
			shuf_q   <= '0;
			j_q      <= '0;
			slot_q   <= '0;
			dq_q     <= '0;
			dsr_q    <= '0;
			rem_q    <= '0;
			cnt_q    <= '0;
			p1_q     <= '0;
			p2_q     <= '0;
			out_q    <= '0;
			out_v_q  <= 1'b0;
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_FIRST_MULT:  a1_q <= pwdata[MULT_W-1:0];
					REG_FIRST_MOD:   m1_q <= pwdata[VAL_W-1:0];
					REG_FIRST_QUOT:  q1_q <= pwdata[VAL_W-1:0];
					REG_FIRST_REM:   r1_q <= pwdata[MULT_W-1:0];
					REG_SECOND_MULT: a2_q <= pwdata[MULT_W-1:0];
					REG_SECOND_MOD:  m2_q <= pwdata[VAL_W-1:0];
					REG_SECOND_QUOT: q2_q <= pwdata[VAL_W-1:0];
					REG_SECOND_REM:  r2_q <= pwdata[MULT_W-1:0];
					default: ;
				endcase
			end
			if (res.valid && res.ready) begin
				out_v_q <= 1'b0;
			end
			if (mem_we) begin
				vld_q[mem_wa] <= 1'b1;
			end
			rd_vld_q <= vld_q[slot_q];

			unique case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						rem_q <= '0;
						cnt_q <= 5'(VAL_W - 1);
						dsr_q <= qq1;
						state_q <= ST_DIV;
						if (op_t'(cmd.op) == OP_RESEED) begin
							phase_q <= PH_RESEED;
							s2_q    <= seed_mag;
							dq_q    <= seed_mag;
							j_q     <= JW'(TABLE_SIZE + 7);
						end else begin
							phase_q <= PH_S1;
							dq_q    <= s1_q;
						end
					end
				end
				ST_DIV: begin
					// one quotient bit a cycle
					rem_q <= fits ? trial[VAL_W-1:0] - dsr_q : trial[VAL_W-1:0];
					dq_q  <= {dq_q[VAL_W-2:0], fits};
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == '0) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (phase_q == PH_TOP) begin
						rem_q   <= '0;
						cnt_q   <= 5'(VAL_W - 1);
						dsr_q   <= dq_q + val_t'(1);
						dq_q    <= shuf_q;
						phase_q <= PH_SLOT;
						state_q <= ST_DIV;
					end else if (phase_q == PH_SLOT) begin
						slot_q  <= slot_sat;
						state_q <= ST_READ;
					end else begin
						p1_q    <= PW'(use2 ? a2_q : a1_q) * PW'(rem_q);
						p2_q    <= PW'(use2 ? r2_q : r1_q) * PW'(dq_q);
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					rem_q   <= '0;
					cnt_q   <= 5'(VAL_W - 1);
					state_q <= ST_DIV;
					unique case (phase_q)
						PH_S1: begin
							s1_q    <= ysch;
							dq_q    <= s2_q;
							dsr_q   <= qq2;
							phase_q <= PH_S2;
						end
						PH_S2: begin
							s2_q    <= ysch;
							dq_q    <= top;
							dsr_q   <= val_t'(TABLE_SIZE);
							phase_q <= PH_TOP;
						end
						default: begin
							dq_q   <= ysch;
							dsr_q  <= qq1;
							j_q    <= j_q - JW'(1);
							if (j_q == '0) begin
								s1_q    <= ysch;
								shuf_q  <= ysch;
								state_q <= ST_IDLE;
							end
						end
					endcase
				end
				ST_READ: begin
					// registered table read lands next cycle
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					shuf_q  <= ynew;
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (!out_v_q || res.ready) begin
						out_q   <= shuf_q;
						out_v_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: bench/combined_lcg_shuffle_rng_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng_test: self-checking bench of the shuffle generator
// Drives draw and reseed words with bursty traffic and a stalling receiver.
// It programs the generator registers between phases and compares every
// returned value with an in-bench model of the two generators and the table.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng_test;
	import clsr_pkg::*;

	localparam int      TBL        = DEF_TABLE_SIZE;
	localparam int      SETTLE     = 34 * (TBL + 8) + 200;
	localparam longint  CYCLE_CAP  = 1000000;
	localparam longint  MASK31     = 64'h7FFF_FFFF;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	clsr_cmd_if cmd ();
	clsr_res_if res ();

	combined_lcg_shuffle_rng DUT (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .res(res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// model state of the generator
	logic [31:0] reg_val [8];
	val_t        gen_one, gen_two, shuffle_acc;
	val_t        slot_store [TBL];
	val_t        pending_values [$];

	int     mismatches;
	int     draws_sent, reseeds_sent, reg_writes, values_checked;
	int     burst_left;
	longint cycle_count;

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_CAP) begin
			$display("timeout after %0d cycles, %0d values pending",
				cycle_count, pending_values.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input longint want, input longint got);
		$display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
		mismatches++;
	endtask

	// one schrage step in wide signed arithmetic
	function automatic val_t schrage_step(val_t x, logic [15:0] a, val_t m, val_t q,
			logic [15:0] r);
		longint qq, xv, k, y;
		qq = (q == 0) ? 64'sd1 : longint'(q);
		xv = longint'(x);
		k  = xv / qq;
		y  = longint'(a) * (xv - k * qq) - longint'(r) * k;
		if (y < 0)
			y += longint'(m);
		return val_t'(y & MASK31);
	endfunction

	function automatic void model_reseed(logic [31:0] raw);
		longint mag;
		val_t   seq;
		if (raw[31]) begin
			mag = 64'h1_0000_0000 - longint'(raw);
			if (mag > MASK31)
				mag = MASK31;
		end else begin
			mag = longint'(raw);
		end
		if (mag == 0)
			mag = 1;
		gen_two = val_t'(mag);
		seq = val_t'(mag);
		for (int j = TBL + 7; j >= 0; j--) begin
			seq = schrage_step(seq, reg_val[REG_FIRST_MULT][15:0], reg_val[REG_FIRST_MOD][30:0],
				reg_val[REG_FIRST_QUOT][30:0], reg_val[REG_FIRST_REM][15:0]);
			if (j < TBL)
				slot_store[j] = seq;
		end
		shuffle_acc = slot_store[0];
		gen_one = seq;
	endfunction

	function automatic val_t model_draw();
		logic [30:0] top;
		logic [31:0] div, slot;
		longint y;
		top = (reg_val[REG_FIRST_MOD][30:0] == 0) ? 31'd0 : reg_val[REG_FIRST_MOD][30:0] - 1;
		div = 32'd1 + 32'(top) / TBL;
		gen_one = schrage_step(gen_one, reg_val[REG_FIRST_MULT][15:0],
			reg_val[REG_FIRST_MOD][30:0], reg_val[REG_FIRST_QUOT][30:0],
			reg_val[REG_FIRST_REM][15:0]);
		gen_two = schrage_step(gen_two, reg_val[REG_SECOND_MULT][15:0],
			reg_val[REG_SECOND_MOD][30:0], reg_val[REG_SECOND_QUOT][30:0],
			reg_val[REG_SECOND_REM][15:0]);
		slot = 32'(shuffle_acc) / div;
		if (slot >= TBL)
			slot = TBL - 1;
		y = longint'(slot_store[slot]) - longint'(gen_two);
		slot_store[slot] = gen_one;
		if (y < 1)
			y += longint'(top);
		shuffle_acc = val_t'(y & MASK31);
		return shuffle_acc;
	endfunction

	// receiver stall pattern: open stretches, then light and heavy stalling
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			case ((cycle_count / 700) % 3)
				0: res.ready <= 1'b1;
				1: res.ready <= ($urandom_range(0, 3) != 0);
				default: res.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			if (pending_values.size() == 0) begin
				report_mismatch("unexpected word, random_value", -1, res.random_value);
			end else begin
				values_checked++;
				if (res.random_value !== pending_values[0])
					report_mismatch("random_value", pending_values[0], res.random_value);
				void'(pending_values.pop_front());
			end
		end
	end

	// send one command word; valid stays high inside a burst
	task automatic send_word(input op_t op, input logic [31:0] seed);
		int gap;
		cmd.valid      <= 1'b1;
		cmd.op         <= op;
		cmd.seed_value <= seed;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
		if (op == OP_RESEED) begin
			model_reseed(seed);
			reseeds_sent++;
		end else begin
			pending_values.push_back(model_draw());
			draws_sent++;
		end
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			if (gap > 0) begin
				cmd.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// stop sending and let the block finish all work
	task automatic drain_all();
		cmd.valid <= 1'b0;
		@(posedge clk);
		while (pending_values.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (idx == REG_FIRST_MULT || idx == REG_FIRST_REM || idx == REG_SECOND_MULT ||
				idx == REG_SECOND_REM)
			reg_val[idx] = value & 32'h0000_FFFF;
		else
			reg_val[idx] = value & 32'h7FFF_FFFF;
		reg_writes++;
	endtask

	task automatic write_all(input logic [31:0] v [8]);
		for (int i = 0; i < 8; i++)
			write_reg(reg_idx_t'(i), v[i]);
	endtask

	// a well-formed schrage set: m = a*q + r with r < q
	task automatic pick_schrage(output logic [31:0] a, m, q, r);
		a = $urandom_range(2, 65535);
		q = $urandom_range(1, 32767);
		r = $urandom_range(0, q - 1);
		m = a * q + r;
	endtask

	task automatic test_unseeded_and_seeds();
		// draws on the zero reset state, then seed sign and zero handling
		send_word(OP_DRAW, 32'h0);
		send_word(OP_DRAW, 32'hFFFF_FFFF);
		send_word(OP_RESEED, 32'h0);
		send_word(OP_DRAW, 32'h0);
		send_word(OP_RESEED, 32'h8000_0000);
		send_word(OP_DRAW, 32'h0);
		send_word(OP_RESEED, 32'h8000_0001);
		send_word(OP_DRAW, 32'h0);
		send_word(OP_RESEED, 32'hFFFF_FFFF);
		send_word(OP_DRAW, 32'h0);
		send_word(OP_RESEED, 32'h7FFF_FFFF);
		for (int i = 0; i < 4; i++)
			send_word(OP_DRAW, $urandom);
		drain_all();
	endtask

	task automatic test_register_extremes();
		logic [31:0] v [8];
		// top values, zero quotient, bottom modulus on the second generator
		v = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0000_FFFF,
			32'h1, 32'h2, 32'h7FFF_FFFF, 32'h0};
		write_all(v);
		send_word(OP_RESEED, 32'd12345);
		for (int i = 0; i < 4; i++)
			send_word(OP_DRAW, 32'h0);
		drain_all();
		// zero first modulus and a small one to push slots past the table
		v = '{32'h1, 32'h0, 32'h1, 32'h0, 32'h0000_FFFF, 32'h0, 32'h0, 32'h0000_FFFF};
		write_all(v);
		send_word(OP_DRAW, 32'h0);
		send_word(OP_RESEED, 32'h7FFF_FFFF);
		send_word(OP_DRAW, 32'h0);
		drain_all();
		v = '{32'd40014, 32'd3, 32'd1, 32'd1, 32'd40692, 32'd2147483399, 32'd52774, 32'd3791};
		write_all(v);
		for (int i = 0; i < 3; i++)
			send_word(OP_DRAW, 32'h0);
		drain_all();
	endtask

	task automatic random_phase(input int count, input int cfg_mode);
		logic [31:0] v [8];
		case (cfg_mode)
			0: v = '{32'(RST_FIRST_MULT), 32'(RST_FIRST_MOD), 32'(RST_FIRST_QUOT),
				32'(RST_FIRST_REM), 32'(RST_SECOND_MULT), 32'(RST_SECOND_MOD),
				32'(RST_SECOND_QUOT), 32'(RST_SECOND_REM)};
			1: begin
				pick_schrage(v[0], v[1], v[2], v[3]);
				pick_schrage(v[4], v[5], v[6], v[7]);
			end
			default: for (int i = 0; i < 8; i++)
				v[i] = $urandom;
		endcase
		write_all(v);
		send_word(OP_RESEED, $urandom);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 11) == 0)
				send_word(OP_RESEED, $urandom);
			else
				send_word(OP_DRAW, $urandom);
		end
	endtask

	task automatic test_random_traffic();
		// sender waits for a full drain after every phase
		random_phase(40, 0);
		drain_all();
		random_phase(60, 0);
		drain_all();
		random_phase(100, 1);
		drain_all();
		random_phase(80, 2);
		drain_all();
		random_phase(100, 1);
		drain_all();
	endtask

	initial begin
		arst_n         = 1'b0;
		cmd.valid      = 1'b0;
		cmd.op         = OP_DRAW;
		cmd.seed_value = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		mismatches = 0; draws_sent = 0; reseeds_sent = 0; reg_writes = 0;
		values_checked = 0; burst_left = 0; cycle_count = 0;
		reg_val = '{32'(RST_FIRST_MULT), 32'(RST_FIRST_MOD), 32'(RST_FIRST_QUOT),
			32'(RST_FIRST_REM), 32'(RST_SECOND_MULT), 32'(RST_SECOND_MOD),
			32'(RST_SECOND_QUOT), 32'(RST_SECOND_REM)};
		gen_one = '0; gen_two = '0; shuffle_acc = '0;
		for (int i = 0; i < TBL; i++)
			slot_store[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unseeded_and_seeds();
		test_register_extremes();
		test_random_traffic();

		$display("covered %0d draws, %0d reseeds, %0d register writes",
			draws_sent, reseeds_sent, reg_writes);
		$display("checked %0d returned values, %0d mismatches", values_checked, mismatches);
		if (mismatches == 0 && pending_values.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
